@@ rtl/core/dssc_pkg.sv @@
`timescale 1ns / 1ps

package dssc_pkg;

  localparam int unsigned ValueW      = 27;
  localparam int unsigned SegW        = 7;
  localparam int unsigned SelW        = 8;
  localparam int unsigned CountW      = 4;
  localparam int unsigned DigitW      = 4;
  localparam int unsigned IdxW        = 3;
  localparam int unsigned DigitsMax   = 8;
  localparam int unsigned MaxDigitsDefault = 8;
  localparam logic [CountW-1:0] DigitCountReset = 4'd7;

  // reciprocal of ten, exact for any 32-bit dividend with a 35-bit shift
  localparam int unsigned RecipW     = 32;
  localparam int unsigned RecipShift = 35;
  localparam logic [RecipW-1:0] RecipTen = 32'hCCCC_CCCD;
  localparam int unsigned ProdW      = ValueW + RecipW;

  typedef logic [DigitsMax-1:0][DigitW-1:0] digits_t;

  function automatic logic [SegW-1:0] seg_code(input logic [DigitW-1:0] digit);
    logic [SegW-1:0] code;
    unique case (digit)
      4'd0:    code = 7'h40;
      4'd1:    code = 7'h79;
      4'd2:    code = 7'h24;
      4'd3:    code = 7'h30;
      4'd4:    code = 7'h19;
      4'd5:    code = 7'h12;
      4'd6:    code = 7'h02;
      4'd7:    code = 7'h78;
      4'd8:    code = 7'h00;
      4'd9:    code = 7'h10;
      default: code = 7'h7F;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/core/dssc_div_stage.sv @@
`timescale 1ns / 1ps

module dssc_div_stage #(
  parameter int unsigned DigitIdx = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [dssc_pkg::ValueW-1:0]   value_i,
  input  dssc_pkg::digits_t             digits_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [dssc_pkg::ValueW-1:0]   value_o,
  output dssc_pkg::digits_t             digits_o
);
  import dssc_pkg::*;

  logic                valid_q;
  logic [ValueW-1:0]   quot_d, quot_q;
  digits_t             digits_d, digits_q;
  logic [ProdW-1:0]    prod;
  logic [ValueW-1:0]   rem;
  logic                load;

  // divide by ten through the reciprocal, remainder by shift and add
  always_comb begin
    prod   = ProdW'(value_i) * ProdW'(RecipTen);
    quot_d = ValueW'(prod >> RecipShift);
    rem    = value_i - ((quot_d << 3) + (quot_d << 1));
    digits_d = digits_i;
    digits_d[DigitIdx] = rem[DigitW-1:0];
  end

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      quot_q   <= quot_d;
      digits_q <= digits_d;
    end
  end

  assign valid_o  = valid_q;
  assign value_o  = quot_q;
  assign digits_o = digits_q;

endmodule

@@ rtl/core/dssc_scan.sv @@
`timescale 1ns / 1ps

module dssc_scan #(
  parameter int unsigned MaxDigits = dssc_pkg::MaxDigitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [dssc_pkg::CountW-1:0]   digit_count_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  dssc_pkg::digits_t             digits_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dssc_pkg::SelW-1:0]     digit_select_o,
  output logic [dssc_pkg::SegW-1:0]     segments_o,
  output logic                          last_digit_o
);
  import dssc_pkg::*;

  logic                busy_d, busy_q;
  logic [IdxW-1:0]     idx_d, idx_q;
  digits_t             digits_q;
  logic                out_valid_d, out_valid_q;
  logic [SelW-1:0]     sel_d, sel_q;
  logic [SegW-1:0]     seg_d, seg_q;
  logic                last_d, last_q;
  logic [CountW-1:0]   count_eff;
  logic                advance;
  logic                is_last;
  logic                take;

  always_comb begin
    if (digit_count_i == '0) begin
      count_eff = CountW'(1);
    end else if (digit_count_i > CountW'(MaxDigits)) begin
      count_eff = CountW'(MaxDigits);
    end else begin
      count_eff = digit_count_i;
    end
  end

  assign advance = !out_valid_q || !out_stall_i;
  assign is_last = (CountW'(idx_q) + CountW'(1)) == count_eff;
  assign ready_o = !busy_q || (advance && is_last);
  assign take    = valid_i && ready_o;

  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    sel_d       = sel_q;
    seg_d       = seg_q;
    last_d      = last_q;
    if (advance) begin
      out_valid_d = busy_q;
      sel_d       = ~(SelW'(8'h80) >> idx_q);
      seg_d       = seg_code(digits_q[idx_q]);
      last_d      = is_last;
      if (busy_q) begin
        idx_d = idx_q + IdxW'(1);
        if (is_last) begin
          busy_d = 1'b0;
        end
      end
    end
    if (take) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q  <= sel_d;
    seg_q  <= seg_d;
    last_q <= last_d;
    if (take) begin
      digits_q <= digits_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign digit_select_o = sel_q;
  assign segments_o     = seg_q;
  assign last_digit_o   = last_q;

endmodule

@@ rtl/core/decimal_seven_segment_scan_core.sv @@
// channel   direction  handshake              payload
// in        input      in_valid_i/in_stall_o  value_i
// out       output     out_valid_o/out_stall_i digit_select_o, segments_o, last_digit_o
// cfg       input      cfg_valid_i/cfg_ready_o cfg_digit_count_i
//
// one divide-by-ten stage per digit, MAX_DIGITS stages, then a scan register
// a value is shown as digit_count digits, clamped to 1..MAX_DIGITS, one digit a cycle unless out_stall_i holds it
// the scan stage takes a new value when idle or on its last digit, which paces the input
// a value passes the divide-stage registers in order, then the scan's digit and output registers
// reset clears all valid bits and loads digit_count with 7
// a stall at the output holds the pipeline in place; nothing is lost or repeated
`timescale 1ns / 1ps

module decimal_seven_segment_scan_core #(
  parameter int unsigned MAX_DIGITS = dssc_pkg::MaxDigitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dssc_pkg::CountW-1:0]   cfg_digit_count_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dssc_pkg::ValueW-1:0]   value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dssc_pkg::SelW-1:0]     digit_select_o,
  output logic [dssc_pkg::SegW-1:0]     segments_o,
  output logic                          last_digit_o
);
  import dssc_pkg::*;

  logic [CountW-1:0] digit_count_q;

  logic [MAX_DIGITS:0]             valid_s;
  logic [MAX_DIGITS:0]             ready_s;
  logic [MAX_DIGITS:0][ValueW-1:0] value_s;
  digits_t [MAX_DIGITS:0]          digits_s;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_count_q <= DigitCountReset;
    end else if (cfg_valid_i) begin
      digit_count_q <= cfg_digit_count_i;
    end
  end

  assign valid_s[0]  = in_valid_i;
  assign value_s[0]  = value_i;
  assign digits_s[0] = '0;
  assign in_stall_o  = !ready_s[0];

  for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_stage
    dssc_div_stage #(
      .DigitIdx(k)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[k]),
      .ready_o (ready_s[k]),
      .value_i (value_s[k]),
      .digits_i(digits_s[k]),
      .valid_o (valid_s[k+1]),
      .ready_i (ready_s[k+1]),
      .value_o (value_s[k+1]),
      .digits_o(digits_s[k+1])
    );
  end

  dssc_scan #(
    .MaxDigits(MAX_DIGITS)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .digit_count_i (digit_count_q),
    .valid_i       (valid_s[MAX_DIGITS]),
    .ready_o       (ready_s[MAX_DIGITS]),
    .digits_i      (digits_s[MAX_DIGITS]),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .digit_select_o(digit_select_o),
    .segments_o    (segments_o),
    .last_digit_o  (last_digit_o)
  );

endmodule

@@ verif/decimal_seven_segment_scan_core_test.sv @@
`timescale 1ns / 1ps

module decimal_seven_segment_scan_core_test;
  import dssc_pkg::*;

  localparam int unsigned RunLimit   = 400000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned HoldAfter  = 100;
  localparam int unsigned PhaseItems = 48;
  localparam int unsigned SettleCycles = 2 * DigitsMax + 8;

  typedef struct packed {
    logic [SelW-1:0] enable_n;
    logic [SegW-1:0] segs;
    logic            last;
  } shown_digit_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [CountW-1:0] cfg_count = '0;
  logic              in_valid = 1'b0;
  logic [ValueW-1:0] in_value = '0;
  logic              out_stall = 1'b0;

  logic              cfg_ready;
  logic              in_stall;
  logic              out_valid;
  logic [SelW-1:0]   digit_select;
  logic [SegW-1:0]   segments;
  logic              last_digit;

  logic [ValueW-1:0] value_queue[$];
  shown_digit_t      digit_expect[$];
  shown_digit_t      want;
  logic [CountW-1:0] shown_count = DigitCountReset;
  logic              value_fire = 1'b0;
  logic              calm = 1'b0;
  logic              held_once = 1'b0;
  int unsigned       send_gap = 0;
  int unsigned       stall_left = 0;
  int unsigned       hold_left = 0;
  int unsigned       values_taken = 0;
  int unsigned       mismatches = 0;
  int unsigned       cycles = 0;

  decimal_seven_segment_scan_core dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_digit_count_i (cfg_count),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .value_i           (in_value),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .digit_select_o    (digit_select),
    .segments_o        (segments),
    .last_digit_o      (last_digit)
  );

  always #2 clk = ~clk;

  function automatic logic [SegW-1:0] glyph_of(input int unsigned d);
    logic [SegW-1:0] g;
    case (d)
      0: g = 7'h40;
      1: g = 7'h79;
      2: g = 7'h24;
      3: g = 7'h30;
      4: g = 7'h19;
      5: g = 7'h12;
      6: g = 7'h02;
      7: g = 7'h78;
      8: g = 7'h00;
      default: g = 7'h10;
    endcase
    return g;
  endfunction

  // split a value into its low decimal digits and queue the scan it should produce
  function automatic void predict_scan(input logic [ValueW-1:0] v, input logic [CountW-1:0] count);
    int unsigned  shown;
    int unsigned  rest;
    shown_digit_t e;
    shown = (count == 0) ? 1 : ((count > DigitsMax) ? DigitsMax : count);
    rest = v;
    for (int unsigned k = 0; k < shown; k++) begin
      e.enable_n = ~(8'h80 >> k);
      e.segs     = glyph_of(rest % 10);
      e.last     = (k + 1 == shown);
      rest       = rest / 10;
      digit_expect.push_back(e);
    end
  endfunction

  function automatic logic [ValueW-1:0] random_value();
    int unsigned p;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return ValueW'($urandom);
      4, 5, 6:    return ValueW'($urandom_range(0, 99999999));
      7:          return ValueW'($urandom_range(0, 999));
      8: begin
        p = 1;
        for (int unsigned k = $urandom_range(1, 8); k > 0; k--) p = p * 10;
        return ValueW'(p - $urandom_range(0, 1));
      end
      default:    return ValueW'($urandom_range(0, 9));
    endcase
  endfunction

  // input transaction accepted: predict its digits
  always @(posedge clk) begin
    value_fire <= in_valid && !in_stall;
    if (in_valid && !in_stall) begin
      predict_scan(in_value, shown_count);
      values_taken <= values_taken + 1;
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || value_fire)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (value_queue.size() > 0) begin
        if (!calm && $urandom_range(0, 9) == 0) begin
          in_valid <= 1'b0;
          send_gap <= $urandom_range(0, 6);
        end else begin
          in_valid <= 1'b1;
          in_value <= value_queue.pop_front();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls, with one long hold-off once the stream is going
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!held_once && values_taken >= HoldAfter) begin
      held_once <= 1'b1;
      hold_left <= HoldCycles - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (digit_expect.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected transaction: sel=%h seg=%h last=%b",
                   digit_select, segments, last_digit);
      end else begin
        want = digit_expect.pop_front();
        if (digit_select !== want.enable_n || segments !== want.segs ||
            last_digit !== want.last) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: expected sel=%h seg=%h last=%b, got sel=%h seg=%h last=%b",
                     want.enable_n, want.segs, want.last,
                     digit_select, segments, last_digit);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RunLimit) begin
      $display("decimal_seven_segment_scan_core_test: errors");
      $finish;
    end
  end

  task automatic drain();
    while (value_queue.size() != 0 || digit_expect.size() != 0 || in_valid)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_digit_count(input logic [CountW-1:0] count);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_count = count;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shown_count = count;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic queue_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) value_queue.push_back(random_value());
  endtask

  logic [CountW-1:0] settings[10] = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd9, 4'd2, 4'd5, 4'd3, 4'd6, 4'd8};

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed values at the reset digit count
    value_queue.push_back(27'd0);
    value_queue.push_back(27'd1);
    value_queue.push_back(27'd9);
    value_queue.push_back(27'd10);
    value_queue.push_back(27'd12345678);
    value_queue.push_back(27'd90817263);
    value_queue.push_back(27'd99999999);
    value_queue.push_back(27'd100000000);
    value_queue.push_back(27'h7FFFFFF);
    value_queue.push_back(27'h4000000);
    value_queue.push_back(27'd9999999);
    value_queue.push_back(27'd10000000);
    value_queue.push_back(27'd44556677);
    drain();

    write_digit_count(4'd0);
    value_queue.push_back(27'd0);
    value_queue.push_back(27'd7);
    value_queue.push_back(27'h7FFFFFF);
    drain();

    write_digit_count(4'd15);
    value_queue.push_back(27'h7FFFFFF);
    value_queue.push_back(27'd99999999);
    value_queue.push_back(27'd12345678);
    value_queue.push_back(27'd5);
    drain();

    write_digit_count(DigitCountReset);
    queue_random(PhaseItems);
    drain();

    foreach (settings[i]) begin
      calm = (i == 3) || (i == 9);
      if (i == 8)
        write_digit_count(CountW'($urandom_range(0, 15)));
      else
        write_digit_count(settings[i]);
      queue_random(PhaseItems - 6);
      drain();
    end

    if (mismatches == 0) begin
      $display("decimal_seven_segment_scan_core_test: clean");
    end else begin
      $display("decimal_seven_segment_scan_core_test: errors");
    end
    $finish;
  end

endmodule

@@ decimal_seven_segment_scan_core.f @@
rtl/core/dssc_pkg.sv
rtl/core/dssc_div_stage.sv
rtl/core/dssc_scan.sv
rtl/core/decimal_seven_segment_scan_core.sv
verif/decimal_seven_segment_scan_core_test.sv
